/* hdl/fba_pkg.sv */
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types and constants of the fragment bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

   localparam int DEF_MAX_FRAGS = 4096;
   localparam int DEF_MAX_FPB   = 8;
   localparam int WORD_BITS     = 8;
   localparam int CNT_W         = 13;
   localparam int ROTOR_W       = 12;
   localparam int DIVIDEND_W    = 32;

   localparam logic [CNT_W-1:0] FREE_BLOCKS_RESET = 13'd512;
   localparam logic [CNT_W-1:0] FREE_FRAGS_RESET  = 13'd0;

   localparam logic [31:0] GROUP_BASE_RESET = 32'd0;
   localparam logic [3:0]  FPB_RESET        = 4'd8;
   localparam logic [12:0] DATA_FRAGS_RESET = 13'd4096;
   localparam logic [4:0]  FRAG_SHIFT_RESET = 5'd12;

   localparam logic [1:0] CMD_ALLOC_BLOCK = 2'd0;
   localparam logic [1:0] CMD_ALLOC_FRAGS = 2'd1;
   localparam logic [1:0] CMD_FREE        = 2'd2;

   localparam logic [1:0] CSR_GROUP_BASE = 2'd0;
   localparam logic [1:0] CSR_FPB        = 2'd1;
   localparam logic [1:0] CSR_DATA_FRAGS = 2'd2;
   localparam logic [1:0] CSR_FRAG_SHIFT = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_DIV_NBLKS,
      ST_DIV_PREF,
      ST_DIV_START,
      ST_SEG,
      ST_SCAN,
      ST_DIV_BLK,
      ST_SWEEP,
      ST_DONE
   } fba_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } fba_div_stat_type;

endpackage

/* hdl/fba_ram.sv */
// ----------------------------------------------------------------------------
// fba_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/fba_div.sv */
// ----------------------------------------------------------------------------
// fba_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fba_div import fba_pkg::*; #(
   parameter int DIVISOR_W = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output fba_div_stat_type      stat,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_BITS = $clog2(DIVIDEND_W);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  take;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      take  = (trial >= {1'b0, dvs_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_ff <= {quo_ff[DIVIDEND_W-2:0], take};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(DIVIDEND_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* hdl/fragment_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// fragment_bitmap_allocator
// Block and fragment allocator over one group's fragment free bitmap.
// ----------------------------------------------------------------------------
// The free bitmap sits in a RAM of 8-bit words; after reset a clearing pass
// over all MAX_FRAGS/8 words (512 by default) fills it with ones before the
// first command transfer is taken. One command is worked at a time. An
// allocation scans the bitmap one word per cycle from the start position,
// wrapping once, checking eight candidate positions per word; the start
// position comes from a serial divider of 32 quotient bits, which is used
// up to three times for a block allocation (plus once more after a hit) and
// once for a fragment allocation. The claim or free is a read-modify-write
// sweep over each word touched, behind the registered RAM read. The result
// is held in an output register, so a new command transfer can be taken
// while it waits.
// ----------------------------------------------------------------------------
module fragment_bitmap_allocator import fba_pkg::*; #(
   parameter int MAX_FRAGS           = DEF_MAX_FRAGS,
   parameter int MAX_FRAGS_PER_BLOCK = DEF_MAX_FPB
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // block_address [31:0], size_bytes [48:32], frag_count [52:49]
   input  logic [55:0] req_tdata,
   // cmd [1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_address [31:0], free_blocks [44:32], free_frags [57:45]
   output logic [63:0] rsp_tdata,
   // found [0]
   output logic [0:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int PW        = $clog2(MAX_FRAGS);
   localparam int NW        = PW + 1;
   localparam int CW        = NW - 3;
   localparam int WORDS     = (MAX_FRAGS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = $clog2(WORDS);
   localparam int COUNT_MAX = (MAX_FRAGS < 8191) ? MAX_FRAGS : 8191;

   // configuration
   logic [31:0] gbase_ff;
   logic [3:0]  fpb_cfg_ff;
   logic [12:0] ndata_ff;
   logic [4:0]  fshift_ff;

   // command
   logic [1:0]  cmd_ff;
   logic [31:0] addr_ff;
   logic [16:0] size_ff;
   logic [3:0]  k_ff;

   // state
   fba_state_type state_ff, state_in;
   logic [CNT_W-1:0]   fbc_ff;
   logic [CNT_W-1:0]   ffc_ff;
   logic [ROTOR_W-1:0] rotor_ff;
   logic [AW-1:0]      clr_ff;

   // scan
   logic          seg_ff;
   logic [NW-1:0] nblks_ff;
   logic [NW-1:0] s_ff;
   logic [NW-1:0] l_ff;
   logic [CW-1:0] cc_ff;
   logic [CW-1:0] iss_ff;
   logic [1:0]    fill_ff;
   logic [7:0]    w0_ff;
   logic [7:0]    w1_ff;
   logic [2:0]    boff_ff;
   logic [NW-1:0] pos_ff;

   // sweep
   logic [NW-1:0] sw_lo_ff;
   logic [NW-1:0] sw_hi_ff;
   logic          sw_set_ff;
   logic          resp_v_ff;
   logic [CW-1:0] resp_a_ff;

   // result
   logic          found_ff;
   logic [31:0]   raddr_ff;
   logic          rsp_valid_ff;
   logic          rsp_found_ff;
   logic [31:0]   rsp_addr_ff;
   logic [CNT_W-1:0] rsp_fbc_ff;
   logic [CNT_W-1:0] rsp_ffc_ff;

   // memory and divider
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [7:0]    mem_rdata;
   logic          div_go;
   logic [DIVIDEND_W-1:0] div_a;
   logic [NW-1:0] div_d;
   fba_div_stat_type div_stat;
   logic [DIVIDEND_W-1:0] div_q;
   logic [NW-1:0] div_r;

   // derived values
   logic [3:0]    fpb_eff;
   logic [NW-1:0] n_eff;
   logic          blk_mode;
   logic [3:0]    k_run;
   logic [31:0]   off32;
   logic [31:0]   s0;
   logic          frag_bad;
   logic [NW-1:0] span;
   logic [16:0]   m17;
   logic          free_in;
   logic [32:0]   end33;
   logic [NW-1:0] free_hi;
   logic [17:0]   ffc_sum;
   logic [13:0]   fbc_sum;
   logic [NW-1:0] lb;
   logic [NW-1:0] ub;
   logic [NW-1:0] ub_m1;
   logic [CW-1:0] cc_last;
   logic [23:0]   win;
   logic [15:0]   kmask16;
   logic [14:0]   kmask;
   logic [7:0]    cand;
   logic          hit;
   logic [2:0]    hit_j;
   logic [NW-1:0] hit_pos;
   logic [2:0]    boff_nxt;
   logic [NW-1:0] sw_hi_m1;
   logic [CW-1:0] sw_wl;
   logic          iss_act;
   logic [7:0]    sw_mask;
   logic [NW-1:0] blk_inc;
   logic [NW+3:0] s_prod;
   logic [NW+3:0] l_prod;
   logic          seg_end;

   assign csr_ready = 1'b1;

   always_comb begin
      if (fpb_cfg_ff == 4'd0) begin
         fpb_eff = 4'd1;
      end else if (fpb_cfg_ff > 4'(MAX_FRAGS_PER_BLOCK)) begin
         fpb_eff = 4'(MAX_FRAGS_PER_BLOCK);
      end else begin
         fpb_eff = fpb_cfg_ff;
      end
      n_eff = (32'(ndata_ff) > 32'(MAX_FRAGS)) ? NW'(MAX_FRAGS) : NW'(ndata_ff);
      blk_mode = (cmd_ff == CMD_ALLOC_BLOCK);
      k_run    = blk_mode ? fpb_eff : k_ff;
      off32    = addr_ff - gbase_ff;
      s0       = (addr_ff > gbase_ff) ? off32 : 32'd0;
      frag_bad = (k_ff == 4'd0) || ((NW + 4)'(k_ff) > (NW + 4)'(n_eff));
      span     = n_eff - NW'(k_ff) + NW'(1);
      m17      = (size_ff == 17'd0) ? 17'(fpb_eff) : (size_ff >> fshift_ff);
      free_in  = (off32 < 32'(n_eff)) && (m17 != 17'd0);
      end33    = {1'b0, off32} + 33'(m17);
      free_hi  = (end33 > 33'(n_eff)) ? n_eff : NW'(end33);
      ffc_sum  = 18'(ffc_ff) + 18'(m17);
      fbc_sum  = 14'(fbc_ff) + 14'd1;
      s_prod   = (NW + 4)'(div_r) * (NW + 4)'(fpb_eff);
      l_prod   = (NW + 4)'(nblks_ff) * (NW + 4)'(fpb_eff);
      blk_inc  = div_q[NW-1:0] + NW'(1);
   end

   // scan window: eight candidate starts per word
   always_comb begin
      logic [14:0]   bits;
      logic [NW-1:0] p;
      logic          algn;
      logic [2:0]    d;
      logic          got;
      logic [6:0]    v;
      lb      = seg_ff ? '0 : s_ff;
      ub      = seg_ff ? s_ff : l_ff;
      ub_m1   = ub - NW'(1);
      cc_last = ub_m1[NW-1:3];
      win     = {mem_rdata, w1_ff, w0_ff};
      kmask16 = (16'd1 << k_run) - 16'd1;
      kmask   = kmask16[14:0];
      for (int j = 0; j < 8; j++) begin
         bits = 15'(win >> j);
         p    = {cc_ff, 3'(j)};
         d    = 3'(j) - boff_ff;
         algn = 1'b0;
         for (int m = 0; m < 8; m++) begin
            if ((3'(j) >= boff_ff) && (6'(d) == 6'(m) * 6'(fpb_eff))) begin
               algn = 1'b1;
            end
         end
         cand[j] = ((bits & kmask) == kmask) && (p >= lb) && (p < ub)
                   && (algn || !blk_mode);
      end
      hit   = |cand;
      hit_j = 3'd0;
      for (int j = 7; j >= 0; j--) begin
         if (cand[j]) begin
            hit_j = 3'(j);
         end
      end
      hit_pos = {cc_ff, hit_j};
      // next block start offset within the following word
      boff_nxt = 3'd0;
      got      = 1'b0;
      for (int m = 1; m <= 8; m++) begin
         v = 7'(boff_ff) + 7'(m) * 7'(fpb_eff);
         if (!got && (v >= 7'd8)) begin
            boff_nxt = 3'(v - 7'd8);
            got      = 1'b1;
         end
      end
      seg_end = (cc_ff == cc_last);
   end

   // sweep mask of the word coming back from the ram
   always_comb begin
      logic [NW-1:0] p;
      sw_hi_m1 = sw_hi_ff - NW'(1);
      sw_wl    = sw_hi_m1[NW-1:3];
      iss_act  = (iss_ff <= sw_wl);
      for (int b = 0; b < 8; b++) begin
         p          = {resp_a_ff, 3'(b)};
         sw_mask[b] = (p >= sw_lo_ff) && (p < sw_hi_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (cmd_ff)
               CMD_ALLOC_BLOCK: state_in = ST_DIV_NBLKS;
               CMD_ALLOC_FRAGS: state_in = frag_bad ? ST_DONE : ST_DIV_START;
               CMD_FREE:        state_in = free_in ? ST_SWEEP : ST_DONE;
               default:         state_in = ST_DONE;
            endcase
         end
         ST_DIV_NBLKS: begin
            if (div_stat.done) begin
               if (div_q[NW-1:0] == '0) begin
                  state_in = ST_DONE;
               end else if (addr_ff != 32'd0) begin
                  state_in = ST_DIV_PREF;
               end else begin
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_DIV_PREF: begin
            if (div_stat.done) begin
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            if (div_stat.done) begin
               state_in = ST_SEG;
            end
         end
         ST_SEG: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (fill_ff == 2'd0) begin
               if (hit) begin
                  state_in = blk_mode ? ST_DIV_BLK : ST_SWEEP;
               end else if (seg_end) begin
                  state_in = (!seg_ff && (s_ff != '0)) ? ST_SEG : ST_DONE;
               end
            end
         end
         ST_DIV_BLK: begin
            if (div_stat.done) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (!iss_act && !resp_v_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs: memory port, divider launch, handshake
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      mem_we     = 1'b0;
      mem_waddr  = clr_ff;
      mem_wdata  = 8'hFF;
      mem_raddr  = iss_ff[AW-1:0];
      div_a      = '0;
      div_d      = NW'(fpb_eff);
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_SEG: begin
            mem_raddr = AW'(lb[NW-1:3]);
         end
         ST_SWEEP: begin
            mem_we    = resp_v_ff;
            mem_waddr = resp_a_ff[AW-1:0];
            mem_wdata = sw_set_ff ? (mem_rdata | sw_mask) : (mem_rdata & ~sw_mask);
         end
         default: begin
         end
      endcase
      div_go = (state_in != state_ff) &&
               ((state_in == ST_DIV_NBLKS) || (state_in == ST_DIV_PREF) ||
                (state_in == ST_DIV_START) || (state_in == ST_DIV_BLK));
      unique case (state_in)
         ST_DIV_NBLKS: div_a = 32'(n_eff);
         ST_DIV_PREF:  div_a = off32;
         ST_DIV_BLK:   div_a = 32'(hit_pos);
         ST_DIV_START: begin
            if (blk_mode) begin
               div_a = (state_ff == ST_DIV_PREF) ? div_q : 32'(rotor_ff);
               div_d = (state_ff == ST_DIV_NBLKS) ? div_q[NW-1:0] : nblks_ff;
            end else begin
               div_a = s0;
               div_d = span;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         gbase_ff     <= GROUP_BASE_RESET;
         fpb_cfg_ff   <= FPB_RESET;
         ndata_ff     <= DATA_FRAGS_RESET;
         fshift_ff    <= FRAG_SHIFT_RESET;
         fbc_ff       <= FREE_BLOCKS_RESET;
         ffc_ff       <= FREE_FRAGS_RESET;
         rotor_ff     <= '0;
         seg_ff       <= 1'b0;
         fill_ff      <= '0;
         resp_v_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         resp_v_ff <= (state_ff == ST_SWEEP) && iss_act;
         resp_a_ff <= iss_ff;

         if (csr_valid) begin
            unique case (csr_index)
               CSR_GROUP_BASE: gbase_ff   <= csr_data;
               CSR_FPB:        fpb_cfg_ff <= csr_data[3:0];
               CSR_DATA_FRAGS: ndata_ff   <= csr_data[12:0];
               CSR_FRAG_SHIFT: fshift_ff  <= csr_data[4:0];
               default: begin
               end
            endcase
         end

         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
            end
            ST_IDLE: begin
               cmd_ff   <= req_tuser;
               addr_ff  <= req_tdata[31:0];
               size_ff  <= req_tdata[48:32];
               k_ff     <= req_tdata[52:49];
               found_ff <= 1'b0;
               raddr_ff <= '0;
            end
            ST_DISPATCH: begin
               if (cmd_ff == CMD_FREE) begin
                  found_ff  <= 1'b1;
                  sw_lo_ff  <= NW'(off32);
                  sw_hi_ff  <= free_hi;
                  sw_set_ff <= 1'b1;
                  iss_ff    <= CW'(off32 >> 3);
                  if (m17 < 17'(fpb_eff)) begin
                     ffc_ff <= (ffc_sum > 18'(COUNT_MAX)) ? CNT_W'(COUNT_MAX)
                                                          : ffc_sum[CNT_W-1:0];
                  end else begin
                     fbc_ff <= (fbc_sum > 14'(COUNT_MAX)) ? CNT_W'(COUNT_MAX)
                                                          : fbc_sum[CNT_W-1:0];
                  end
               end
            end
            ST_DIV_NBLKS: begin
               nblks_ff <= div_q[NW-1:0];
            end
            ST_DIV_START: begin
               seg_ff <= 1'b0;
               if (blk_mode) begin
                  s_ff <= s_prod[NW-1:0];
                  l_ff <= l_prod[NW-1:0];
               end else begin
                  s_ff <= div_r;
                  l_ff <= span;
               end
            end
            ST_SEG: begin
               cc_ff   <= lb[NW-1:3];
               iss_ff  <= lb[NW-1:3] + 1'b1;
               fill_ff <= 2'd2;
               boff_ff <= lb[2:0];
            end
            ST_SCAN: begin
               iss_ff <= iss_ff + 1'b1;
               if (fill_ff != 2'd0) begin
                  w0_ff   <= w1_ff;
                  w1_ff   <= mem_rdata;
                  fill_ff <= fill_ff - 1'b1;
               end else if (hit) begin
                  pos_ff <= hit_pos;
                  if (!blk_mode) begin
                     found_ff  <= 1'b1;
                     raddr_ff  <= gbase_ff + 32'(hit_pos);
                     sw_lo_ff  <= hit_pos;
                     sw_hi_ff  <= hit_pos + NW'(k_ff);
                     sw_set_ff <= 1'b0;
                     iss_ff    <= hit_pos[NW-1:3];
                     ffc_ff    <= (ffc_ff > CNT_W'(k_ff)) ? ffc_ff - CNT_W'(k_ff) : '0;
                  end
               end else if (seg_end) begin
                  seg_ff <= 1'b1;
               end else begin
                  w0_ff   <= w1_ff;
                  w1_ff   <= mem_rdata;
                  cc_ff   <= cc_ff + 1'b1;
                  boff_ff <= boff_nxt;
               end
            end
            ST_DIV_BLK: begin
               if (div_stat.done) begin
                  found_ff  <= 1'b1;
                  raddr_ff  <= gbase_ff + 32'(pos_ff);
                  sw_lo_ff  <= pos_ff;
                  sw_hi_ff  <= pos_ff + NW'(fpb_eff);
                  sw_set_ff <= 1'b0;
                  iss_ff    <= pos_ff[NW-1:3];
                  fbc_ff    <= (fbc_ff > CNT_W'(1)) ? fbc_ff - CNT_W'(1) : '0;
                  rotor_ff  <= (blk_inc == nblks_ff) ? '0 : ROTOR_W'(blk_inc);
               end
            end
            ST_SWEEP: begin
               if (iss_act) begin
                  iss_ff <= iss_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase

         if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
            rsp_found_ff <= found_ff;
            rsp_addr_ff  <= found_ff ? raddr_ff : 32'd0;
            rsp_fbc_ff   <= fbc_ff;
            rsp_ffc_ff   <= ffc_ff;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {6'd0, rsp_ffc_ff, rsp_fbc_ff, rsp_addr_ff};
   assign rsp_tuser[0] = rsp_found_ff;

   fba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   fba_div #(
      .DIVISOR_W (NW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (div_go),
      .dividend  (div_a),
      .divisor   (div_d),
      .stat      (div_stat),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // the bitmap is never written while a search reads it
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_SEG) |-> !mem_we)
      else $error("bitmap written during scan");

   // a division is only launched on an idle divider
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_go |-> !div_stat.busy)
      else $error("divider launched while busy");

   // a sweep always covers at least one fragment
   a_sweep_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (sw_hi_ff > sw_lo_ff))
      else $error("empty sweep range");

   // a failed or unknown command answers with address zero
   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_addr_ff == 32'd0))
      else $error("nonzero address on failure");

   // input transfers are only taken with the bitmap initialized
   a_clear_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("transfer taken during clearing pass");

endmodule
